// ===== rtl/button_action_auto_repeat_core_defines.svh =====
// Assertion macros for the RTL file that carries checks (bar_back).
`ifndef BUTTON_ACTION_AUTO_REPEAT_CORE_DEFINES_SVH
`define BUTTON_ACTION_AUTO_REPEAT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BAR_ASSERT_IMP(lbl, ante, cons)
`define BAR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/bar_pkg.sv =====
package bar_pkg;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_UP    = 3'd1;
    localparam logic [2:0] ACT_DOWN  = 3'd2;
    localparam logic [2:0] ACT_LEFT  = 3'd3;
    localparam logic [2:0] ACT_RIGHT = 3'd4;
    localparam logic [2:0] ACT_ENTER = 3'd5;
    localparam logic [2:0] ACT_BACK  = 3'd6;

    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_ENTER = 4;
    localparam int BTN_BACK  = 5;

    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_RATE  = 1'b1;

    localparam logic [15:0] DELAY_RESET = 16'd400;
    localparam logic [15:0] RATE_RESET  = 16'd100;

    // Both queues hold two words; pointers are one bit and wrap by overflow.
    localparam logic [1:0] Q_FULL_CNT = 2'd2;

    typedef struct packed {
        logic        key;
        logic [2:0]  act;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_fb;

endpackage

// ===== rtl/button_action_auto_repeat_core.sv =====
// Button action decoder with typematic auto-repeat. Each poll sample word (six button
// levels and a millisecond time stamp) is pushed into a two-word input queue while
// full is low, and exactly one action word per sample comes out of a two-word result
// queue in the same order. One sample is taken every clock cycle while full is low (an
// unpopped result queue backs up and raises it); the decision stage updates its state
// (last action and time base) as each word is taken and writes each result word on.
// The configuration port is always ready; registers should be written only while idle.
module button_action_auto_repeat_core import bar_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  i_pressed,
    input  logic [31:0] i_now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_action,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_delay;
    logic [15:0] r_rate;
    t_fb         w_fb;
    logic        w_fb_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_rate  <= RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELAY: r_delay <= i_cfg_data;
                CFG_RATE:  r_rate  <= i_cfg_data;
                default:   r_rate  <= r_rate;
            endcase
        end
    end

    bar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_pressed  (i_pressed),
        .i_now_ms   (i_now_ms),
        .o_fb       (w_fb),
        .i_fb_ready (w_fb_ready)
    );

    bar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fb       (w_fb),
        .o_fb_ready (w_fb_ready),
        .i_delay    (r_delay),
        .i_rate     (r_rate),
        .empty      (empty),
        .pop        (pop),
        .o_action   (o_action)
    );

endmodule

// ===== rtl/bar_front.sv =====
module bar_front import bar_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [5:0] i_pressed,
    input  logic [31:0] i_now_ms,
    output t_fb        o_fb,
    input  logic       i_fb_ready
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       n_wr_ptr;
    logic       r_rd_ptr;
    logic       n_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    function automatic logic [2:0] pick_dir(input logic [5:0] p);
        logic [2:0] d;
        d = ACT_NONE;
        if (p[BTN_LEFT] != p[BTN_RIGHT]) begin
            d = p[BTN_LEFT] ? ACT_LEFT : ACT_RIGHT;
        end else if (p[BTN_UP] != p[BTN_DOWN]) begin
            d = p[BTN_UP] ? ACT_UP : ACT_DOWN;
        end
        return d;
    endfunction

    always_comb begin
        w_cmd.now = i_now_ms;
        w_cmd.key = i_pressed[BTN_ENTER] | i_pressed[BTN_BACK];
        if (i_pressed[BTN_ENTER]) begin
            w_cmd.act = ACT_ENTER;
        end else if (i_pressed[BTN_BACK]) begin
            w_cmd.act = ACT_BACK;
        end else begin
            w_cmd.act = pick_dir(i_pressed);
        end
    end

    assign full       = (r_cnt == Q_FULL_CNT);
    assign w_push     = push && !full;
    assign o_fb.valid = (r_cnt != 2'd0);
    assign o_fb.cmd   = r_mem[r_rd_ptr];
    assign w_pop      = o_fb.valid && i_fb_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== rtl/bar_back.sv =====
`include "button_action_auto_repeat_core_defines.svh"

module bar_back import bar_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fb         i_fb,
    output logic        o_fb_ready,
    input  logic [15:0] i_delay,
    input  logic [15:0] i_rate,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_action
);

    logic [2:0]  r_last;
    logic [2:0]  n_last;
    logic [31:0] r_time;
    logic [31:0] n_time;
    logic [2:0]  w_res;
    logic [31:0] w_elapsed;
    logic        w_take;
    logic        w_pop;
    logic [2:0]  r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    assign o_fb_ready = (r_cnt != Q_FULL_CNT);
    assign w_take     = i_fb.valid && o_fb_ready;
    assign empty      = (r_cnt == 2'd0);
    assign w_pop      = pop && !empty;
    assign o_action   = r_mem[r_rd_ptr];
    assign w_elapsed  = i_fb.cmd.now - r_time;

    always_comb begin
        n_last = r_last;
        n_time = r_time;
        w_res  = ACT_NONE;
        if (i_fb.cmd.key) begin
            if (i_fb.cmd.act != r_last) begin
                n_last = i_fb.cmd.act;
                w_res  = i_fb.cmd.act;
            end
        end else if (i_fb.cmd.act != r_last) begin
            if (w_elapsed >= {17'd0, i_rate[15:1]}) begin
                n_last = i_fb.cmd.act;
                n_time = i_fb.cmd.now;
                w_res  = i_fb.cmd.act;
            end
        end else if (i_fb.cmd.act != ACT_NONE) begin
            if (w_elapsed >= {16'd0, i_delay}) begin
                n_time = i_fb.cmd.now - {16'd0, i_delay} + {16'd0, i_rate};
                w_res  = i_fb.cmd.act;
            end
        end
        n_cnt = r_cnt + {1'b0, w_take} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= ACT_NONE;
            r_time   <= 32'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_take) begin
                r_last   <= n_last;
                r_time   <= n_time;
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mem[r_wr_ptr] <= w_res;
        end
    end

    `BAR_ASSERT_NXT(a_key_latched, w_take && i_fb.cmd.key, r_last == $past(i_fb.cmd.act))
    `BAR_ASSERT_NXT(a_word_counted, w_take && !w_pop, r_cnt == $past(r_cnt) + 2'd1)
    `BAR_ASSERT_NXT(a_idle_holds_state, !w_take, $stable(r_last) && $stable(r_time))

endmodule
